>>> hdl/srbs_pkg.sv
// Shared types and constants for the sorted range binary search block.
// Used by srbs_cell, srbs_result_buf and sorted_range_binary_search_top.
package srbs_pkg;

    localparam int DATA_W   = 64;
    localparam int OUTIDX_W = 8;
    localparam int CFG_W    = 9;

    // Operation codes of the input channel.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Control that travels with a search token along the cell chain.
    typedef struct packed {
        logic valid;
        logic hit;
    } t_probe_ctl;

    // One finished lookup result.
    typedef struct packed {
        logic                found;
        logic [OUTIDX_W-1:0] index;
        logic [DATA_W-1:0]   low;
        logic [DATA_W-1:0]   high;
    } t_result;

endpackage

>>> hdl/srbs_cell.sv
// One probe step of the search chain, with its own copy of the range table.
// Depends on srbs_pkg.
module srbs_cell
    import srbs_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int IDX_W       = 8,
    parameter int CNT_W       = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_start,
    input  logic [DATA_W-1:0] i_wr_end,
    input  t_probe_ctl        i_ctl,
    input  logic [CNT_W-1:0]  i_lo,
    input  logic [CNT_W-1:0]  i_hi_ex,
    input  logic [DATA_W-1:0] i_addr,
    input  logic [IDX_W-1:0]  i_res_index,
    input  logic [DATA_W-1:0] i_res_low,
    input  logic [DATA_W-1:0] i_res_high,
    output t_probe_ctl        o_ctl,
    output logic [CNT_W-1:0]  o_lo,
    output logic [CNT_W-1:0]  o_hi_ex,
    output logic [DATA_W-1:0] o_addr,
    output logic [IDX_W-1:0]  o_res_index,
    output logic [DATA_W-1:0] o_res_low,
    output logic [DATA_W-1:0] o_res_high
);

    logic [DATA_W-1:0] r_mem_start [MAX_ENTRIES];
    logic [DATA_W-1:0] r_mem_end   [MAX_ENTRIES];

    logic [CNT_W:0]    w_sum;
    logic [CNT_W-1:0]  w_half;
    logic [IDX_W-1:0]  w_mid;
    logic              w_active;

    t_probe_ctl        r_ctl;
    logic              r_active;
    logic [CNT_W-1:0]  r_lo;
    logic [CNT_W-1:0]  r_hi_ex;
    logic [IDX_W-1:0]  r_mid;
    logic [DATA_W-1:0] r_addr;
    logic [IDX_W-1:0]  r_res_index;
    logic [DATA_W-1:0] r_res_low;
    logic [DATA_W-1:0] r_res_high;
    logic [DATA_W-1:0] r_rd_start;
    logic [DATA_W-1:0] r_rd_end;

    // The window is [lo, hi_ex); the probe sits at floor((lo + hi_ex - 1) / 2).
    assign w_active = i_ctl.valid && !i_ctl.hit && (i_lo < i_hi_ex);
    assign w_sum    = {1'b0, i_lo} + {1'b0, i_hi_ex} - {{CNT_W{1'b0}}, 1'b1};
    assign w_half   = w_sum[CNT_W:1];
    assign w_mid    = w_half[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_start[i_wr_addr] <= i_wr_start;
            r_mem_end[i_wr_addr]   <= i_wr_end;
        end
        r_rd_start <= r_mem_start[w_mid];
        r_rd_end   <= r_mem_end[w_mid];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= '0;
            r_active <= 1'b0;
        end else begin
            r_ctl    <= i_ctl;
            r_active <= w_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= i_lo;
        r_hi_ex     <= i_hi_ex;
        r_mid       <= w_mid;
        r_addr      <= i_addr;
        r_res_index <= i_res_index;
        r_res_low   <= i_res_low;
        r_res_high  <= i_res_high;
    end

    // Compare against the probed entry and narrow the window for the next cell.
    always_comb begin
        o_ctl       = r_ctl;
        o_lo        = r_lo;
        o_hi_ex     = r_hi_ex;
        o_addr      = r_addr;
        o_res_index = r_res_index;
        o_res_low   = r_res_low;
        o_res_high  = r_res_high;
        if (r_active) begin
            if (r_addr < r_rd_start) begin
                o_hi_ex = CNT_W'(r_mid);
            end else if (r_rd_end <= r_addr) begin
                o_lo = CNT_W'(r_mid) + CNT_W'(1);
            end else begin
                o_ctl.hit   = 1'b1;
                o_res_index = r_mid;
                o_res_low   = r_rd_start;
                o_res_high  = r_rd_end - {{(DATA_W-1){1'b0}}, 1'b1};
            end
        end
    end

endmodule

>>> hdl/srbs_result_buf.sv
// Output register with one skid entry for finished lookup results.
// Depends on srbs_pkg.
module srbs_result_buf
    import srbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_result o_out,
    output logic    o_skid_full
);

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid;
    t_result n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = i_res_valid;
                n_skid       = i_res;
            end else begin
                n_out_valid = i_res_valid;
                n_out       = i_res;
            end
        end else if (i_res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_skid_full = r_skid_valid;

endmodule

>>> hdl/sorted_range_binary_search_top.sv
// Top level of the sorted range binary search block: cell chain and result buffer.
// Depends on srbs_pkg, srbs_cell and srbs_result_buf.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_ready   operation, entry index/start/length,
//                                                  query address
//   output    out        o_out_valid / i_out_ready found, match index, range low/high
//   config    in         i_cfg_valid / o_cfg_ready entry_count (always ready)
//
// A write transfer puts the entry into every cell's table copy at the accepting
// edge. A lookup walks a chain of NUM_CELLS probe cells (9 for 256 entries), one
// cell per cycle, and its result is registered into the result buffer as it leaves
// the last cell; no new item is taken until then.
// Reset clears the entry count and all control state; the tables are not
// cleared and need no clearing pass. A result that is not taken waits in the
// output register, and one more lookup may complete into a skid entry behind it.
module sorted_range_binary_search_top
    import srbs_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  logic [7:0]          i_entry_index,
    input  logic [DATA_W-1:0]   i_entry_start,
    input  logic [DATA_W-1:0]   i_entry_length,
    input  logic [DATA_W-1:0]   i_query_address,
    // Output channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_found,
    output logic [OUTIDX_W-1:0] o_match_index,
    output logic [DATA_W-1:0]   o_range_low,
    output logic [DATA_W-1:0]   o_range_high,
    // Configuration channel.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    // A search over up to MAX_ENTRIES entries needs at most this many probes.
    localparam int NUM_CELLS = CNT_W;

    logic              r_busy;
    logic [CFG_W-1:0]  r_entry_count;
    logic [CNT_W-1:0]  w_count;

    logic              w_in_xfer;
    logic              w_is_lookup;
    logic              w_slot_ok;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    logic [DATA_W-1:0] w_wr_end;

    t_probe_ctl        w_ctl       [NUM_CELLS+1];
    logic [CNT_W-1:0]  w_lo        [NUM_CELLS+1];
    logic [CNT_W-1:0]  w_hi_ex     [NUM_CELLS+1];
    logic [DATA_W-1:0] w_addr      [NUM_CELLS+1];
    logic [IDX_W-1:0]  w_res_index [NUM_CELLS+1];
    logic [DATA_W-1:0] w_res_low   [NUM_CELLS+1];
    logic [DATA_W-1:0] w_res_high  [NUM_CELLS+1];

    logic              w_done;
    t_result           w_result;
    t_result           w_out;
    logic              w_skid_full;

    // Always ready; the user must write configuration only while idle (unenforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // Counts above the table size search the whole table.
    always_comb begin
        if (32'(r_entry_count) > 32'(MAX_ENTRIES)) begin
            w_count = CNT_W'(MAX_ENTRIES);
        end else begin
            w_count = CNT_W'(r_entry_count);
        end
    end

    // One item in flight at a time, and no new item while the skid entry is held.
    assign o_in_ready  = !r_busy && !w_skid_full;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_is_lookup = (i_operation == OP_LOOKUP);

    // Writes to slots past the table are dropped. The table keeps the range end
    // (start plus length, wrapping) so that a probe needs only two compares.
    assign w_slot_ok = ({24'd0, i_entry_index} < 32'(MAX_ENTRIES));
    assign w_wr_en   = w_in_xfer && (i_operation == OP_WRITE) && w_slot_ok;
    assign w_wr_addr = IDX_W'(i_entry_index);
    assign w_wr_end  = i_entry_start + i_entry_length;

    // A lookup enters the first cell directly from the input ports.
    assign w_ctl[0]       = '{valid: w_in_xfer && w_is_lookup, hit: 1'b0};
    assign w_lo[0]        = '0;
    assign w_hi_ex[0]     = w_count;
    assign w_addr[0]      = i_query_address;
    assign w_res_index[0] = '0;
    assign w_res_low[0]   = '0;
    assign w_res_high[0]  = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        srbs_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .IDX_W       (IDX_W),
            .CNT_W       (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (w_wr_en),
            .i_wr_addr   (w_wr_addr),
            .i_wr_start  (i_entry_start),
            .i_wr_end    (w_wr_end),
            .i_ctl       (w_ctl[g]),
            .i_lo        (w_lo[g]),
            .i_hi_ex     (w_hi_ex[g]),
            .i_addr      (w_addr[g]),
            .i_res_index (w_res_index[g]),
            .i_res_low   (w_res_low[g]),
            .i_res_high  (w_res_high[g]),
            .o_ctl       (w_ctl[g+1]),
            .o_lo        (w_lo[g+1]),
            .o_hi_ex     (w_hi_ex[g+1]),
            .o_addr      (w_addr[g+1]),
            .o_res_index (w_res_index[g+1]),
            .o_res_low   (w_res_low[g+1]),
            .o_res_high  (w_res_high[g+1])
        );
    end

    // The token leaves the last cell with its result; a miss carries zeros.
    assign w_done         = w_ctl[NUM_CELLS].valid;
    assign w_result.found = w_ctl[NUM_CELLS].hit;
    assign w_result.index = OUTIDX_W'(w_res_index[NUM_CELLS]);
    assign w_result.low   = w_res_low[NUM_CELLS];
    assign w_result.high  = w_res_high[NUM_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_in_xfer && w_is_lookup) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    srbs_result_buf u_result_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_done),
        .i_res       (w_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (w_out),
        .o_skid_full (w_skid_full)
    );

    assign o_found       = w_out.found;
    assign o_match_index = w_out.index;
    assign o_range_low   = w_out.low;
    assign o_range_high  = w_out.high;

endmodule

>>> verif/tb.sv
// Self-checking testbench for sorted_range_binary_search_top: a directed table of table
// writes, lookups and entry-count settings, then random sorted tables probed by lookups.
// Depends on srbs_pkg and the RTL top level; each result is checked against a shadow search or a typed answer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srbs_pkg::*;

    localparam int TABLE_SLOTS = 256;
    // The slack covers the nine probe cells, the output register and the skid.
    localparam int DRAIN_SLACK = 16;
    localparam int LONG_HOLD   = 200;
    localparam int IDLE_LIMIT  = 2000;
    localparam int ITEM_TARGET = 1100;
    localparam int REPORT_MAX  = 10;

    localparam t_result NO_MATCH  = '0;
    // First entry of the directed table: 0x1000 .. 0x10FF.
    localparam t_result FIRST_HIT = {1'b1, 8'd0, 64'h1000, 64'h10FF};

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_LOOKUP,
        ROW_CHECKED,
        ROW_COUNT
    } t_row_kind;

    // One directed row. For a write, a is the start and b the length; for a lookup, a is
    // the address; for a count row, a holds the new entry count. The typed answer is used
    // by ROW_CHECKED rows only.
    typedef struct packed {
        t_row_kind           kind;
        logic [7:0]          slot;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
        t_result             answer;
    } t_plan_row;

    // Clock, reset and every block input start at a known value.
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic                i_operation     = OP_WRITE;
    logic [7:0]          i_entry_index   = '0;
    logic [DATA_W-1:0]   i_entry_start   = '0;
    logic [DATA_W-1:0]   i_entry_length  = '0;
    logic [DATA_W-1:0]   i_query_address = '0;
    logic                i_out_ready     = 1'b0;
    logic                i_cfg_valid     = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data      = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_found;
    logic [OUTIDX_W-1:0] o_match_index;
    logic [DATA_W-1:0]   o_range_low;
    logic [DATA_W-1:0]   o_range_high;
    logic                o_cfg_ready;

    sorted_range_binary_search_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_entry_index   (i_entry_index),
        .i_entry_start   (i_entry_start),
        .i_entry_length  (i_entry_length),
        .i_query_address (i_query_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_match_index   (o_match_index),
        .o_range_low     (o_range_low),
        .o_range_high    (o_range_high),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the range table and the entry count, updated at each accepted transfer.
    logic [DATA_W-1:0] shadow_start [TABLE_SLOTS];
    logic [DATA_W-1:0] shadow_len   [TABLE_SLOTS];
    bit                slot_written [TABLE_SLOTS];
    logic [CFG_W-1:0]  shadow_count = '0;

    // Answers still owed by the block, oldest first.
    t_result lookup_answers [$];
    t_plan_row directed_plan [$];

    int n_writes      = 0;
    int n_lookups     = 0;
    int n_hits        = 0;
    int n_settings    = 0;
    int n_mismatch    = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int hold_requests = 0;
    int burst_left    = 5;
    int idle_cycles   = 0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Binary search over the first entry_count slots, probing (low + high) / 2 each step.
    // The end of a range is start + length, wrapped to 64 bits.
    function automatic t_result search_table(input logic [DATA_W-1:0] addr);
        t_result           res;
        int                lo;
        int                hi;
        int                mid;
        bit                done;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] e;
        res  = NO_MATCH;
        lo   = 0;
        hi   = ((shadow_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(shadow_count)) - 1;
        done = 1'b0;
        while (!done && lo <= hi) begin
            mid = (lo + hi) / 2;
            s   = shadow_start[mid];
            e   = s + shadow_len[mid];
            if (addr < s) begin
                hi = mid - 1;
            end else if (e <= addr) begin
                lo = mid + 1;
            end else begin
                res.found = 1'b1;
                res.index = mid[OUTIDX_W-1:0];
                res.low   = s;
                res.high  = e - 64'd1;
                done      = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_plan_row plan(input t_row_kind kind, input logic [7:0] slot,
                                       input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                                       input t_result answer);
        t_plan_row row;
        row.kind   = kind;
        row.slot   = slot;
        row.a      = a;
        row.b      = b;
        row.answer = answer;
        return row;
    endfunction

    // Caps the wanted entry count so that its probes only ever touch slots written since reset.
    function automatic logic [CFG_W-1:0] cap_to_written(input logic [CFG_W-1:0] want);
        int filled;
        int need;
        filled = 0;
        while (filled < TABLE_SLOTS && slot_written[filled]) filled++;
        need = (want > TABLE_SLOTS) ? TABLE_SLOTS : int'(want);
        return (need <= filled) ? want : filled[CFG_W-1:0];
    endfunction

    // Query address around a random entry among the first `slots`: its edges, just outside
    // them, somewhere inside, or anywhere at all.
    function automatic logic [DATA_W-1:0] pick_address(input int slots);
        int                j;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] l;
        logic [DATA_W-1:0] addr;
        j = $urandom_range(0, slots - 1);
        s = shadow_start[j];
        l = shadow_len[j];
        case ($urandom_range(0, 9))
            0: addr = s;
            1: addr = s + l - 64'd1;
            2: addr = s + l;
            3: addr = s - 64'd1;
            4: addr = rand64();
            5: addr = $urandom_range(0, 1) ? '1 : '0;
            default: addr = (l == 0) ? s : s + (rand64() % l);
        endcase
        return addr;
    endfunction

    // Offer one item and hold it until the block takes it. The shadow table or the answer
    // queue is updated at the edge where the transfer happens. Valid is only lowered when a
    // burst ends, so back-to-back items keep it high without a glitch.
    task automatic send_item(input logic op, input logic [7:0] slot,
                             input logic [DATA_W-1:0] st, input logic [DATA_W-1:0] len,
                             input logic [DATA_W-1:0] addr, input bit typed,
                             input t_result answer);
        t_result guess;
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_entry_index   <= slot;
        i_entry_start   <= st;
        i_entry_length  <= len;
        i_query_address <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == OP_WRITE) begin
            shadow_start[slot] = st;
            shadow_len[slot]   = len;
            slot_written[slot] = 1'b1;
            n_writes++;
        end else begin
            guess = typed ? answer : search_table(addr);
            lookup_answers.push_back(guess);
            n_lookups++;
            if (guess.found) n_hits++;
        end
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            // Gap lengths straddle the lookup latency so idle cycles land on every probe stage.
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Stop offering, wait for every owed answer, then let a write still in flight settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (lookup_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Entry count is only changed with the block idle.
    task automatic set_count(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_count = value;
        n_settings++;
        i_cfg_valid <= 1'b0;
    endtask

    // Load slots 0 .. slots-1 with ascending starts. The stride sets the scale of the
    // table; lengths are sometimes zero, sometimes fill the stride, and sometimes huge so
    // that the end wraps past the top of the address space.
    task automatic load_table(input int slots);
        logic [DATA_W-1:0] stride;
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] st;
        logic [DATA_W-1:0] len;
        int                w;
        w      = $urandom_range(1, 55);
        stride = (rand64() >> (64 - w)) | (64'd1 << (w - 1));
        span   = stride * slots;
        base   = rand64();
        if (base > ~span) base = ~span;
        for (int i = 0; i < slots; i++) begin
            st = base + stride * i + (rand64() % ((stride >> 1) + 64'd1));
            case ($urandom_range(0, 7))
                0: len = '0;
                1: len = stride;
                2: len = rand64();
                default: len = (rand64() % stride) + 64'd1;
            endcase
            send_item(OP_WRITE, i[7:0], st, len, rand64(), 1'b0, NO_MATCH);
        end
    endtask

    // Result checker: each result transfer is matched against the oldest owed answer.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (lookup_answers.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= REPORT_MAX) begin
                    $display("unexpected result: found=%0b index=%0d low=%h high=%h",
                             o_found, o_match_index, o_range_low, o_range_high);
                end
            end else begin
                want = lookup_answers.pop_front();
                if (o_found !== want.found || o_match_index !== want.index ||
                    o_range_low !== want.low || o_range_high !== want.high) begin
                    n_mismatch++;
                    if (n_mismatch <= REPORT_MAX) begin
                        $display("result %0d mismatch: expected found=%0b index=%0d low=%h high=%h",
                                 results_seen, want.found, want.index, want.low, want.high);
                        $display("    actual found=%0b index=%0d low=%h high=%h",
                                 o_found, o_match_index, o_range_low, o_range_high);
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer on any channel means the block hung.
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("stalled for %0d cycles with %0d answers owed",
                     idle_cycles, lookup_answers.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Result receiver. It switches among always-ready, mostly-ready, mostly-stalled and a
    // fixed one-in-four pattern. On request from the stimulus it holds off for a long
    // stretch while items keep coming, so the output register and skid entry fill and the
    // block has to stall its input.
    initial begin : result_sink
        int mode;
        int span;
        int tick;
        int holds_done;
        mode       = 0;
        span       = 0;
        tick       = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done < hold_requests) begin
                holds_done++;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 120);
            end
            span--;
            tick++;
            case (mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (tick % 4 == 0);
            endcase
        end
    end

    // Main stimulus: reset, the directed table, then random phases.
    initial begin : stimulus
        int               phase;
        int               table_size;
        int               slots;
        int               ops;
        logic [CFG_W-1:0] want;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Slot 1 first holds a zero-length range and later an out-of-order
        // start; slot 3 wraps past the top of the address space; slot 255 holds all ones.
        directed_plan.push_back(plan(ROW_COUNT,   8'd0,   64'd0, 64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_CHECKED, 8'd0,   64'd0, 64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_CHECKED, 8'd0,   '1,    64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_WRITE,   8'd0,   64'h1000, 64'h100, NO_MATCH));
        directed_plan.push_back(plan(ROW_WRITE,   8'd1,   64'h2000, 64'h0, NO_MATCH));
        directed_plan.push_back(plan(ROW_WRITE,   8'd2,   64'h8000_0000_0000_0000,
                                     64'h7FFF_FFFF_FFFF_FFFF, NO_MATCH));
        directed_plan.push_back(plan(ROW_WRITE,   8'd3,   64'hFFFF_FFFF_FFFF_FF00,
                                     64'h200, NO_MATCH));
        directed_plan.push_back(plan(ROW_WRITE,   8'd255, '1,    '1,    NO_MATCH));
        directed_plan.push_back(plan(ROW_COUNT,   8'd0,   64'd4, 64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_CHECKED, 8'd0,   64'h1000, 64'd0, FIRST_HIT));
        directed_plan.push_back(plan(ROW_CHECKED, 8'd0,   64'h10FF, 64'd0, FIRST_HIT));
        directed_plan.push_back(plan(ROW_LOOKUP,  8'd0,   64'h1100, 64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_LOOKUP,  8'd0,   64'h0FFF, 64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_LOOKUP,  8'd0,   64'h2000, 64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_LOOKUP,  8'd0,   64'h8000_0000_0000_0000, 64'd0,
                                     NO_MATCH));
        directed_plan.push_back(plan(ROW_LOOKUP,  8'd0,   64'hFFFF_FFFF_FFFF_FFFE, 64'd0,
                                     NO_MATCH));
        directed_plan.push_back(plan(ROW_LOOKUP,  8'd0,   64'hFFFF_FFFF_FFFF_FF00, 64'd0,
                                     NO_MATCH));
        directed_plan.push_back(plan(ROW_LOOKUP,  8'd0,   '1,    64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_WRITE,   8'd1,   64'h0, 64'h10, NO_MATCH));
        directed_plan.push_back(plan(ROW_LOOKUP,  8'd0,   64'h8,    64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_LOOKUP,  8'd0,   64'h1000, 64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_COUNT,   8'd0,   64'd1, 64'd0, NO_MATCH));
        directed_plan.push_back(plan(ROW_CHECKED, 8'd0,   64'h10FF, 64'd0, FIRST_HIT));

        foreach (directed_plan[k]) begin
            case (directed_plan[k].kind)
                ROW_WRITE: begin
                    send_item(OP_WRITE, directed_plan[k].slot, directed_plan[k].a,
                              directed_plan[k].b, '0, 1'b0, NO_MATCH);
                end
                ROW_LOOKUP: begin
                    send_item(OP_LOOKUP, 8'd0, '0, '0, directed_plan[k].a, 1'b0, NO_MATCH);
                end
                ROW_CHECKED: begin
                    send_item(OP_LOOKUP, 8'd0, '0, '0, directed_plan[k].a, 1'b1,
                              directed_plan[k].answer);
                end
                default: begin
                    set_count(directed_plan[k].a[CFG_W-1:0]);
                end
            endcase
        end

        // Random phases: load a sorted table, pick an entry count, then mostly lookups near
        // the loaded ranges with a few stray writes that may break the ordering. The first
        // phase fills every slot so that counts above the table size are legal from then on;
        // the second reuses that table with a count of exactly the table size.
        phase      = 0;
        table_size = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase == 0 || phase == 9) begin
                table_size = TABLE_SLOTS;
            end else if (phase != 1) begin
                table_size = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 64 : 12);
            end
            if (phase != 1) load_table(table_size);

            if (phase == 0) begin
                want = '1;
            end else if (phase == 1) begin
                want = CFG_W'(TABLE_SLOTS);
            end else begin
                case ($urandom_range(0, 7))
                    0: want = '0;
                    1: want = CFG_W'($urandom_range(0, table_size));
                    2: want = CFG_W'($urandom_range(TABLE_SLOTS + 1, 511));
                    3: want = CFG_W'(1);
                    default: want = CFG_W'(table_size);
                endcase
            end
            set_count(cap_to_written(want));

            // Addresses come from entries the count can reach; with a count of zero, from the loaded table.
            slots = (shadow_count == 0) ? table_size
                  : ((shadow_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(shadow_count));
            ops = $urandom_range(20, 60);
            for (int j = 0; j < ops; j++) begin
                if (j == 8 && phase % 4 == 2) hold_requests++;
                if ($urandom_range(0, 9) == 0) begin
                    send_item(OP_WRITE, 8'($urandom_range(0, 255)), rand64(), rand64(),
                              rand64(), 1'b0, NO_MATCH);
                end else begin
                    send_item(OP_LOOKUP, 8'($urandom_range(0, 255)), rand64(), rand64(),
                              pick_address(slots), 1'b0, NO_MATCH);
                end
            end
            phase++;
        end

        wait_idle();

        $display("Covered %0d table writes and %0d lookups (%0d hits) over %0d count settings",
                 n_writes, n_lookups, n_hits, n_settings);
        $display("in %0d random phases with %0d long output stalls; %0d mismatches.",
                 phase, hold_requests, n_mismatch);
        if (n_mismatch == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
